/* design/stereo_elastic_fifo_drop_oldest_core_defines.svh */
// Assertion macros shared by the stereo elastic FIFO RTL.
`ifndef STEREO_ELASTIC_FIFO_DROP_OLDEST_CORE_DEFINES_SVH
`define STEREO_ELASTIC_FIFO_DROP_OLDEST_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SEFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SEFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/sefd_pkg.sv */
// Shared constants and types for the stereo elastic FIFO.
package sefd_pkg;

	localparam int unsigned RING_FRAMES_DEF = 65536;

	localparam int SAMPLE_W = 16;
	localparam int FRAME_W  = 2 * SAMPLE_W;
	localparam int LEVEL_W  = 16;
	localparam int COUNT_W  = 32;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 4;

	localparam logic [LEVEL_W-1:0] TARGET_LEVEL_RST = 16'd2205;
	localparam logic [LEVEL_W-1:0] DROP_LEVEL_RST   = 16'd8820;

	typedef enum logic [1:0] {
		REG_TARGET  = 2'd0,
		REG_DROP    = 2'd1,
		REG_CAPTURE = 2'd2
	} reg_idx_t;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

endpackage

/* design/stereo_elastic_fifo_drop_oldest_core.sv */
// Stereo elastic FIFO: frame ring with drop-oldest overflow and underrun counting.
// Push word: written to the frame RAM at the accept edge, no result.
// Pushes sustain one word per cycle while no pop is in flight.
// Pop word: states LEVEL, REM, MOD (target modulo pipeline), PTR, READ (registered RAM read), DONE;
// the pop holds in_stall until its result loads in DONE, which waits while the output is stalled.
// Reset (arst_n low) clears pointers, counters and out_valid and loads register defaults; the frame RAM is not cleared.
module stereo_elastic_fifo_drop_oldest_core #(
	parameter int unsigned RING_FRAMES = sefd_pkg::RING_FRAMES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// item channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  mode,
	input  logic signed [sefd_pkg::SAMPLE_W-1:0]  left_in,
	input  logic signed [sefd_pkg::SAMPLE_W-1:0]  right_in,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [sefd_pkg::SAMPLE_W-1:0]  left_out,
	output logic signed [sefd_pkg::SAMPLE_W-1:0]  right_out,
	output logic                                  was_empty,
	output logic                                  dropped_now,
	output logic [sefd_pkg::COUNT_W-1:0]          underrun_total,
	output logic [sefd_pkg::COUNT_W-1:0]          drop_total,
	// configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [sefd_pkg::ADDR_W-1:0]           paddr,
	input  logic [sefd_pkg::DATA_W-1:0]           pwdata,
	output logic [sefd_pkg::DATA_W-1:0]           prdata,
	output logic                                  pready
);

	`include "stereo_elastic_fifo_drop_oldest_core_defines.svh"

	localparam int LW = sefd_pkg::LEVEL_W;
	localparam int CW = sefd_pkg::COUNT_W;
	localparam int PW = $clog2(RING_FRAMES);
	// common width for pointer and level arithmetic
	localparam int XW = ((PW > LW) ? PW : LW) + 1;
	localparam logic [XW-1:0] RING_X = XW'(RING_FRAMES);

	// target % RING_FRAMES by reciprocal: q = (t * MULT) >> SHIFT is floor or floor-1
	localparam int SHIFT = LW + PW;
	localparam longint unsigned MULT = (64'd1 << SHIFT) / RING_FRAMES;
	localparam int MW  = $clog2(MULT + 1);
	localparam int PRW = LW + MW;
	localparam int QRW = LW + PW + 1;
	localparam logic [MW-1:0] MULT_V = MW'(MULT);
	localparam logic [QRW-1:0] RING_Q = QRW'(RING_FRAMES);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LEVEL = 7'b0000010,
		ST_REM   = 7'b0000100,
		ST_MOD   = 7'b0001000,
		ST_PTR   = 7'b0010000,
		ST_READ  = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [LW-1:0] target_q;
	logic [LW-1:0] drop_lvl_q;
	logic          capture_q;

	// ring pointers and counters
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] underrun_q;
	logic [CW-1:0] drops_q;

	// pop pipeline
	logic [PW-1:0]  level_s1;
	logic [PRW-1:0] prod_s1;
	logic [LW-1:0]  rem_s2;
	logic [PW-1:0]  tmod_s3;
	logic           drop_s3;
	logic [PW-1:0]  rd_s4;
	logic           empty_s4;

	// output register
	logic                       out_valid_q;
	logic [sefd_pkg::FRAME_W-1:0] frame_out_q;
	logic                       empty_out_q;
	logic                       drop_out_q;
	logic [CW-1:0]              underrun_out_q;
	logic [CW-1:0]              drops_out_q;

	logic [sefd_pkg::FRAME_W-1:0] ram_rdata;
	logic                       cfg_wr;
	logic                       in_acc;
	logic                       push_acc;
	logic                       pop_acc;
	logic                       out_free;
	logic [PW-1:0]              wr_inc;
	logic [PW-1:0]              rd_inc;
	logic [XW-1:0]              level_x;
	logic [PRW-1:0]             prod_sh;
	logic [LW-1:0]              quo;
	logic [QRW-1:0]             qr;
	logic [XW-1:0]              rem_x;
	logic [XW-1:0]              tmod_x;
	logic [XW-1:0]              rd_drop_x;
	sefd_pkg::reg_idx_t         reg_sel;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;
	assign reg_sel  = sefd_pkg::reg_idx_t'(paddr[3:2]);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid & ~in_stall;
	assign push_acc = in_acc & (mode == sefd_pkg::MODE_PUSH);
	assign pop_acc  = in_acc & (mode == sefd_pkg::MODE_POP);
	assign out_free = ~out_valid_q | ~out_stall;

	// pointer advance with wrap at the ring size
	assign wr_inc = (XW'(wr_q) + XW'(1) == RING_X) ? '0 : PW'(XW'(wr_q) + XW'(1));
	assign rd_inc = (XW'(rd_s4) + XW'(1) == RING_X) ? '0 : PW'(XW'(rd_s4) + XW'(1));

	// fill level modulo the ring
	assign level_x = (wr_q >= rd_q) ? (XW'(wr_q) - XW'(rd_q))
	                                : (XW'(wr_q) + RING_X - XW'(rd_q));

	// reciprocal quotient and remainder of the target level
	assign prod_sh = prod_s1 >> SHIFT;
	assign quo     = LW'(prod_sh);
	assign qr      = QRW'(quo) * RING_Q;

	// one correction step brings the remainder below the ring size
	assign rem_x   = XW'(rem_s2);
	assign tmod_x  = (rem_x >= RING_X) ? (rem_x - RING_X) : rem_x;

	// read pointer after a drop: write pointer minus target, wrapped
	assign rd_drop_x = (wr_q >= tmod_s3) ? (XW'(wr_q) - XW'(tmod_s3))
	                                     : (XW'(wr_q) + RING_X - XW'(tmod_s3));

	// configuration writes and reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= sefd_pkg::TARGET_LEVEL_RST;
			drop_lvl_q <= sefd_pkg::DROP_LEVEL_RST;
			capture_q  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				sefd_pkg::REG_TARGET:  target_q   <= pwdata[LW-1:0];
				sefd_pkg::REG_DROP:    drop_lvl_q <= pwdata[LW-1:0];
				sefd_pkg::REG_CAPTURE: capture_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			sefd_pkg::REG_TARGET:  prdata = sefd_pkg::DATA_W'(target_q);
			sefd_pkg::REG_DROP:    prdata = sefd_pkg::DATA_W'(drop_lvl_q);
			sefd_pkg::REG_CAPTURE: prdata = sefd_pkg::DATA_W'(capture_q);
			default:               prdata = '0;
		endcase
	end

	// pop sequencer, pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wr_q       <= '0;
			rd_q       <= '0;
			underrun_q <= '0;
			drops_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					// advance the write pointer on push; start the sequence on pop
					if (push_acc) begin
						wr_q <= wr_inc;
					end
					if (pop_acc) begin
						state_q <= ST_LEVEL;
					end
				end
				ST_LEVEL: state_q <= ST_REM;
				ST_REM:   state_q <= ST_MOD;
				ST_MOD:   state_q <= ST_PTR;
				ST_PTR:   state_q <= ST_READ;
				ST_READ: begin
					// commit the read pointer and bump the saturating counters
					rd_q <= empty_s4 ? rd_s4 : rd_inc;
					if (drop_s3 && (drops_q != '1)) begin
						drops_q <= drops_q + CW'(1);
					end
					if (empty_s4 && capture_q && (underrun_q != '1)) begin
						underrun_q <= underrun_q + CW'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register can take the word
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// pop datapath stages
	always_ff @(posedge clk) begin
		if (pop_acc) begin
			level_s1 <= PW'(level_x);
			prod_s1  <= PRW'(target_q) * PRW'(MULT_V);
		end
		if (state_q == ST_LEVEL) begin
			rem_s2 <= LW'(QRW'(target_q) - qr);
		end
		if (state_q == ST_REM) begin
			tmod_s3 <= PW'(tmod_x);
			drop_s3 <= (XW'(level_s1) > XW'(drop_lvl_q));
		end
		if (state_q == ST_MOD) begin
			rd_s4    <= drop_s3 ? PW'(rd_drop_x) : rd_q;
			empty_s4 <= drop_s3 ? (target_q == '0) : (level_s1 == '0);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			frame_out_q    <= empty_s4 ? '0 : ram_rdata;
			empty_out_q    <= empty_s4;
			drop_out_q     <= drop_s3;
			underrun_out_q <= underrun_q;
			drops_out_q    <= drops_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign left_out       = frame_out_q[sefd_pkg::SAMPLE_W-1:0];
	assign right_out      = frame_out_q[sefd_pkg::FRAME_W-1:sefd_pkg::SAMPLE_W];
	assign was_empty      = empty_out_q;
	assign dropped_now    = drop_out_q;
	assign underrun_total = underrun_out_q;
	assign drop_total     = drops_out_q;

	// frame ring: left sample in the low half
	sefd_ram #(
		.WIDTH(sefd_pkg::FRAME_W),
		.DEPTH(RING_FRAMES)
	) u_frames (
		.clk    (clk),
		.wr_en  (push_acc),
		.wr_addr(wr_q),
		.wr_data({right_in, left_in}),
		.rd_en  (state_q == ST_READ),
		.rd_addr(rd_s4),
		.rd_data(ram_rdata)
	);

	`SEFD_ASSERT_NOW(a_ptr_range, 1'b1, (XW'(wr_q) < RING_X) && (XW'(rd_q) < RING_X), "ring pointer out of range")
	`SEFD_ASSERT_NEXT(a_push_adv, push_acc, wr_q == $past(wr_inc), "write pointer did not advance on push")
	`SEFD_ASSERT_NOW(a_empty_silent, out_valid && was_empty, (left_out == '0) && (right_out == '0), "empty pop returned nonzero samples")
	`SEFD_ASSERT_NOW(a_drop_count, out_valid && dropped_now, drop_total != '0, "drop reported with zero drop count")

endmodule

/* design/sefd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module sefd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* test/tb_top.sv */
// Testbench for the stereo elastic FIFO: random push/pop words, predicted pops, config phases.
module tb_top;
	import sefd_pkg::*;

	// Generous ceiling: the slowest legal run stays well below this.
	localparam int unsigned CYCLE_LIMIT  = 3_000_000;
	// Index past the last register; writes there must be ignored.
	localparam int          UNMAPPED_REG = 3;
	// Cycles to let a pop settle before a register write or the end of the run.
	localparam int          SETTLE_CYCLES = 8;
	// Frames pushed before every store entry has been written at least once.
	localparam int unsigned RING_SIZE    = RING_FRAMES_DEF;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [LEVEL_W-1:0]         ring_ptr_t;

	typedef struct packed {
		logic    mode;
		sample_t left;
		sample_t right;
	} fifo_word_t;

	typedef struct {
		sample_t            left;
		sample_t            right;
		logic               was_empty;
		logic               dropped_now;
		logic [COUNT_W-1:0] underruns;
		logic [COUNT_W-1:0] drops;
	} pop_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                mode = MODE_PUSH;
	sample_t             left_in = '0;
	sample_t             right_in = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	sample_t             left_out;
	sample_t             right_out;
	logic                was_empty;
	logic                dropped_now;
	logic [COUNT_W-1:0]  underrun_total;
	logic [COUNT_W-1:0]  drop_total;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	stereo_elastic_fifo_drop_oldest_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .left_in(left_in), .right_in(right_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.left_out(left_out), .right_out(right_out),
		.was_empty(was_empty), .dropped_now(dropped_now),
		.underrun_total(underrun_total), .drop_total(drop_total),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Register shadow, shared by the stimulus planner and the predictor.
	// Both only change while the block is idle, so one copy serves both.
	// ---------------------------------------------------------------------
	logic [LEVEL_W-1:0] cfg_target  = TARGET_LEVEL_RST;
	logic [LEVEL_W-1:0] cfg_drop    = DROP_LEVEL_RST;
	logic               cfg_capture = 1'b0;
	int unsigned        settings_used = 0;

	// Predicted ring contents and pointers, advanced at each accepted word.
	logic [FRAME_W-1:0] frame_ram [RING_SIZE];
	ring_ptr_t          ring_wr = '0;
	ring_ptr_t          ring_rd = '0;
	logic [COUNT_W-1:0] underrun_cnt = '0;
	logic [COUNT_W-1:0] drop_cnt = '0;
	pop_result_t        awaited_results [$];

	// Planner copy of the pointers, run ahead at generation time so that no
	// pop ever lands on a store entry that was never written since reset.
	ring_ptr_t          plan_wr = '0;
	ring_ptr_t          plan_rd = '0;
	int unsigned        plan_pushed = 0;

	fifo_word_t         word_queue [$];
	int unsigned        words_issued = 0;
	int unsigned        words_accepted = 0;
	int unsigned        pushes_seen = 0;
	int unsigned        pops_seen = 0;
	int unsigned        empty_pops = 0;
	int unsigned        drop_pops = 0;
	int unsigned        mismatches = 0;
	int unsigned        cycle_count = 0;

	// ---------------------------------------------------------------------
	// Pointer math of one pop: where the oldest frame sits, whether the
	// overflow jump fires, and the level that is left to read from.
	// The ring is 2^16 frames, so 16-bit wraparound is the modulo.
	// ---------------------------------------------------------------------
	function automatic void locate_oldest(input ring_ptr_t wr, input ring_ptr_t rd,
			input logic [LEVEL_W-1:0] target, input logic [LEVEL_W-1:0] drop,
			output ring_ptr_t from, output logic jumped, output logic [LEVEL_W-1:0] lvl);
		lvl    = wr - rd;
		jumped = lvl > drop;
		from   = jumped ? ring_ptr_t'(wr - target) : rd;
		if (jumped)
			lvl = target;
	endfunction

	function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Apply one register write to the shadow; mask to width, ignore unknown.
	function automatic void apply_register(input int idx, input logic [DATA_W-1:0] data);
		case (idx)
			REG_TARGET:  cfg_target  = data[LEVEL_W-1:0];
			REG_DROP:    cfg_drop    = data[LEVEL_W-1:0];
			REG_CAPTURE: cfg_capture = data[0];
			default: ;
		endcase
	endfunction

	// Advance the predicted ring by one accepted word; a pop queues its result.
	task automatic advance_ring(input fifo_word_t w);
		ring_ptr_t          from;
		logic               jumped;
		logic [LEVEL_W-1:0] lvl;
		pop_result_t        r;
		logic [FRAME_W-1:0] frame;
		if (w.mode == MODE_PUSH) begin
			frame_ram[ring_wr] = {w.right, w.left};
			ring_wr++;
			pushes_seen++;
		end else begin
			locate_oldest(ring_wr, ring_rd, cfg_target, cfg_drop, from, jumped, lvl);
			if (jumped) begin
				drop_cnt = bump(drop_cnt);
				drop_pops++;
			end
			if (lvl == 0) begin
				// Nothing to read: answer silence, count only while capturing.
				frame = '0;
				if (cfg_capture)
					underrun_cnt = bump(underrun_cnt);
				ring_rd = from;
				empty_pops++;
			end else begin
				frame   = frame_ram[from];
				ring_rd = from + 1'b1;
			end
			r.left        = frame[SAMPLE_W-1:0];
			r.right       = frame[FRAME_W-1:SAMPLE_W];
			r.was_empty   = (lvl == 0);
			r.dropped_now = jumped;
			r.underruns   = underrun_cnt;
			r.drops       = drop_cnt;
			awaited_results.insert(awaited_results.size(), r);
			pops_seen++;
		end
	endtask

	// ---------------------------------------------------------------------
	// Stimulus planning.
	// ---------------------------------------------------------------------
	function automatic sample_t random_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return '0;
			3: return '1;
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic void plan_push(input sample_t l, input sample_t r);
		word_queue.insert(word_queue.size(), fifo_word_t'{MODE_PUSH, l, r});
		plan_wr++;
		plan_pushed++;
		words_issued++;
	endfunction

	// Queue a pop unless it would read a store entry never written since reset.
	function automatic bit plan_pop();
		ring_ptr_t          from;
		logic               jumped;
		logic [LEVEL_W-1:0] lvl;
		locate_oldest(plan_wr, plan_rd, cfg_target, cfg_drop, from, jumped, lvl);
		if (lvl != 0 && plan_pushed < RING_SIZE && from >= plan_pushed)
			return 1'b0;
		plan_rd = (lvl != 0) ? ring_ptr_t'(from + 1'b1) : from;
		word_queue.insert(word_queue.size(),
			fifo_word_t'{MODE_POP, random_sample(), random_sample()});
		words_issued++;
		return 1'b1;
	endfunction

	// Bursts of one kind so the fill level wanders up and down.
	task automatic plan_random(input int count, input int push_pct);
		int  n;
		int  len;
		bit  pushing;
		n = 0;
		while (n < count) begin
			pushing = ($urandom_range(0, 99) < push_pct);
			len     = $urandom_range(1, 12);
			repeat (len) begin
				if (pushing || !plan_pop())
					plan_push(random_sample(), random_sample());
				n++;
			end
		end
	endtask

	// Hold until every word is taken and every pop has answered, then settle.
	task automatic wait_drained();
		while (words_accepted != words_issued || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, access cycle, then release once pready confirms the write.
	task automatic apb_write(input int idx, input logic [DATA_W-1:0] data);
		logic [ADDR_W-1:0] addr;
		addr = ADDR_W'(idx * 4);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		apply_register(idx, data);
	endtask

	// Write all three registers with junk in the unused upper bits.
	task automatic set_config(input int target, input int drop, input bit capture);
		apb_write(REG_TARGET, {16'($urandom), 16'(target)});
		apb_write(REG_DROP, {16'($urandom), 16'(drop)});
		apb_write(REG_CAPTURE, {31'($urandom), capture});
		settings_used++;
	endtask

	task automatic run_phase(input int target, input int drop, input bit capture,
			input int count, input int push_pct);
		wait_drained();
		set_config(target, drop, capture);
		plan_random(count, push_pct);
	endtask

	// ---------------------------------------------------------------------
	// Idle patterns: mostly short, a few long, with calm stretches between.
	// ---------------------------------------------------------------------
	int send_calm = 0;
	int recv_calm = 0;

	function automatic int pick_gap();
		int r;
		if (send_calm > 0) begin
			send_calm--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0)
			send_calm = $urandom_range(10, 60);
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_stall();
		int r;
		if (recv_calm > 0) begin
			recv_calm--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0)
			recv_calm = $urandom_range(10, 60);
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	// ---------------------------------------------------------------------
	// Driver: present the next queued word once the current one is taken.
	// Feed the predictor at the edge that accepts a word.
	// ---------------------------------------------------------------------
	fifo_word_t held_word;
	int         idle_left = 0;

	always @(posedge clk) begin : word_driver
		logic fire;
		fire = (in_valid === 1'b1) && (in_stall === 1'b0);
		if (fire) begin
			advance_ring(held_word);
			words_accepted++;
		end
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (fire || !in_valid) begin
			if (idle_left > 0) begin
				idle_left--;
				in_valid <= 1'b0;
			end else if (word_queue.size() > 0) begin
				held_word = word_queue.pop_front();
				in_valid  <= 1'b1;
				mode      <= held_word.mode;
				left_in   <= held_word.left;
				right_in  <= held_word.right;
				idle_left = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: match each taken result word against the oldest pop awaiting
	// one, and toggle the receiver stall.
	// ---------------------------------------------------------------------
	int stall_left = 0;

	task automatic note_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [COUNT_W-1:0] got,
			input logic [COUNT_W-1:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	always @(posedge clk) begin : result_monitor
		pop_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (awaited_results.size() == 0) begin
				note_mismatch("result word with no pop awaiting it");
			end else begin
				want = awaited_results.pop_front();
				check_field("left_out", left_out, want.left);
				check_field("right_out", right_out, want.right);
				check_field("was_empty", was_empty, want.was_empty);
				check_field("dropped_now", dropped_now, want.dropped_now);
				check_field("underrun_total", underrun_total, want.underruns);
				check_field("drop_total", drop_total, want.drops);
			end
		end
		if (stall_left == 0)
			stall_left = pick_stall();
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Hard stop if the run hangs.
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pops still awaited",
				cycle_count, awaited_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Sequence: directed words, then random phases over several settings.
	// ---------------------------------------------------------------------
	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings, capture off: empty pop counts no underrun, extreme
		// samples come back in order, then the ring is empty again.
		void'(plan_pop());
		plan_push(16'sh8000, 16'sh7FFF);
		plan_push(16'sh7FFF, 16'sh8000);
		plan_push('0, '1);
		plan_push('1, '0);
		plan_push(16'sh5555, 16'shAAAA);
		repeat (6) void'(plan_pop());

		// Capture on with tiny levels: empty pop counts an underrun, an
		// overflow jumps back to the newest frame, a stray register is ignored.
		wait_drained();
		set_config(1, 3, 1'b1);
		apb_write(UNMAPPED_REG, $urandom);
		void'(plan_pop());
		repeat (6) plan_push(random_sample(), random_sample());
		void'(plan_pop());
		void'(plan_pop());

		// Zero target: the jump lands on the write pointer and answers empty.
		wait_drained();
		set_config(0, 0, 1'b1);
		plan_push(random_sample(), random_sample());
		plan_push(random_sample(), random_sample());
		void'(plan_pop());
		void'(plan_pop());

		// Random phases over several settings, extremes included.
		run_phase(2205, 8820, 1'b0, 200, 55);
		run_phase(0, 0, 1'b1, 200, 60);
		run_phase(1, 2, 1'b1, 200, 55);
		run_phase(5, 20, 1'b0, 200, 58);
		run_phase(16, 16, 1'b1, 200, 55);
		run_phase(40, 12, 1'b1, 200, 60);
		run_phase(65535, 65535, 1'b1, 200, 50);
		run_phase($urandom_range(0, 48), $urandom_range(0, 80), 1'($urandom), 200, 55);

		// Large targets: a pop whose jump would land on frames never written
		// turns into a push, so the level climbs until only pushes remain.
		run_phase(65535, 100, 1'b1, 80, 45);
		run_phase(30000, 1000, 1'b0, 80, 45);
		run_phase(12, 0, 1'b1, 80, 50);

		wait_drained();
		$display("ran %0d words: %0d pushes, %0d pops (%0d empty, %0d with a drop)",
			words_accepted, pushes_seen, pops_seen, empty_pops, drop_pops);
		$display("under %0d register settings in %0d cycles, %0d mismatches",
			settings_used, cycle_count, mismatches);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
